// ----- sv/itoa_pkg.sv -----
// Shared types, constants and the digit character table for the integer to ASCII unit.
`default_nettype none

package itoa_pkg;

  // Field widths fixed by the transaction format.
  localparam int RADIX_W = 5;
  localparam int CHAR_W  = 7;
  localparam int DIGIT_W = 4;

  // Legal radix range.
  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

  // Dividend bits retired by the divide unit in one cycle.
  localparam int DIV_STEP = 8;

  // Character emitted on a bad radix.
  localparam logic [CHAR_W-1:0] ERROR_CHAR = 7'h00;

  // Lower-case digit characters, indexed by digit value.
  localparam logic [CHAR_W-1:0] DIGIT_CHARS [16] = '{
    7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
    7'h38, 7'h39, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66
  };

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_EMIT
  } state_t;

  // Map a digit value to its ASCII character.
  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
    return DIGIT_CHARS[d];
  endfunction

endpackage

`default_nettype wire

// ----- sv/itoa_if.sv -----
// Valid/ready stream interfaces for the input and result channels of the integer to ASCII unit.
`default_nettype none

interface itoa_in_if import itoa_pkg::*; #(
  parameter int VALUE_BITS = 32
) ();
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;
  logic [RADIX_W-1:0]    radix;

  modport source (output valid, output value, output radix, input ready);
  modport sink   (input valid, input value, input radix, output ready);
endinterface

interface itoa_out_if import itoa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] digit_char;
  logic              last;
  logic              bad_radix;

  modport source (output valid, output digit_char, output last, output bad_radix,
                  input ready);
  modport sink   (input valid, input digit_char, input last, input bad_radix,
                  output ready);
endinterface

`default_nettype wire

// ----- sv/radix_integer_to_ascii_unit.sv -----
// Top level of the unsigned integer to ASCII converter for radix 2 to 16.
`default_nettype none

// Converts an unsigned VALUE_BITS-wide value to lower-case ASCII digits in a radix from
// 2 to 16, most significant digit first, one result transaction per digit, with last set
// on the final digit. A zero value gives the single digit '0'. A radix outside 2..16
// gives one result with bad_radix and last set and digit_char zero. Digits come from a
// shared restoring divide unit that retires 8 dividend bits per cycle, and each digit
// takes one pass over the whole dividend; remainders are pushed on a digit stack and
// then popped to the result register at one per cycle while that register is empty or
// its result is taken. The input is not ready while an item is in progress; the last
// result may still wait in the output register while the next item is taken. The item
// interface must be instantiated with the same VALUE_BITS.
module radix_integer_to_ascii_unit import itoa_pkg::*; #(
  parameter int VALUE_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  itoa_in_if.sink    item,
  itoa_out_if.source result
);

  localparam int DIV_BITS = ((VALUE_BITS + DIV_STEP - 1) / DIV_STEP) * DIV_STEP;
  localparam int CHUNKS   = DIV_BITS / DIV_STEP;
  localparam int CHUNK_W  = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int CNT_W    = $clog2(VALUE_BITS + 1);

  // Sequencer and control registers.
  state_t             state, state_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [CHUNK_W-1:0] chunk, chunk_next;
  logic               bad, bad_next;
  logic               out_valid, out_valid_next;

  // Datapath registers.
  logic [DIV_BITS-1:0] work, work_next;
  logic [RADIX_W-1:0]  radix_r, radix_r_next;
  logic [DIGIT_W-1:0]  rem, rem_next;
  logic                qnz, qnz_next;
  logic [DIGIT_W-1:0]  stack [VALUE_BITS];
  logic                push, pop;

  // Result register.
  logic [CHAR_W-1:0] out_char, out_char_next;
  logic              out_last, out_last_next;
  logic              out_bad, out_bad_next;

  // Divide unit outputs.
  logic [DIGIT_W:0]    div_rem;
  logic [DIV_STEP-1:0] div_q;

  logic item_fire, load_out, radix_bad;

  // The input is taken only between items.
  assign item.ready = (state == ST_IDLE);
  assign item_fire  = item.valid && item.ready;
  assign radix_bad  = (item.radix < RADIX_MIN) || (item.radix > RADIX_MAX);

  // Restoring divide of the next 8 dividend bits by the radix.
  always_comb begin
    div_rem = {1'b0, rem};
    div_q   = '0;
    for (int i = 0; i < DIV_STEP; i++) begin
      div_rem = {div_rem[DIGIT_W-1:0], work[DIV_BITS-1-i]};
      if (div_rem >= radix_r) begin
        div_rem             = div_rem - radix_r;
        div_q[DIV_STEP-1-i] = 1'b1;
      end
    end
  end

  // Next state, datapath control and result register loading.
  always_comb begin
    state_next     = state;
    count_next     = count;
    chunk_next     = chunk;
    bad_next       = bad;
    work_next      = work;
    radix_r_next   = radix_r;
    rem_next       = rem;
    qnz_next       = qnz;
    push           = 1'b0;
    pop            = 1'b0;
    load_out       = 1'b0;
    out_char_next  = out_char;
    out_last_next  = out_last;
    out_bad_next   = out_bad;

    case (state)
      ST_IDLE: begin
        if (item_fire) begin
          work_next    = DIV_BITS'(item.value);
          radix_r_next = item.radix;
          rem_next     = '0;
          qnz_next     = 1'b0;
          chunk_next   = '0;
          count_next   = '0;
          bad_next     = radix_bad;
          state_next   = radix_bad ? ST_EMIT : ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        work_next = (work << DIV_STEP) | DIV_BITS'(div_q);
        qnz_next  = qnz || (div_q != '0);
        rem_next  = div_rem[DIGIT_W-1:0];
        if (chunk == CHUNK_W'(CHUNKS - 1)) begin
          // Digit done: push the remainder and go on while the quotient is nonzero.
          push       = 1'b1;
          count_next = count + CNT_W'(1);
          chunk_next = '0;
          rem_next   = '0;
          qnz_next   = 1'b0;
          if (!(qnz || (div_q != '0))) begin
            state_next = ST_EMIT;
          end
        end else begin
          chunk_next = chunk + CHUNK_W'(1);
        end
      end
      ST_EMIT: begin
        if (!out_valid || result.ready) begin
          load_out = 1'b1;
          if (bad) begin
            out_char_next = ERROR_CHAR;
            out_last_next = 1'b1;
            out_bad_next  = 1'b1;
            state_next    = ST_IDLE;
          end else begin
            pop           = 1'b1;
            out_char_next = digit_to_char(stack[0]);
            out_last_next = (count == CNT_W'(1));
            out_bad_next  = 1'b0;
            count_next    = count - CNT_W'(1);
            if (count == CNT_W'(1)) begin
              state_next = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    out_valid_next = load_out || (out_valid && !result.ready);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      chunk     <= '0;
      bad       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      chunk     <= chunk_next;
      bad       <= bad_next;
      out_valid <= out_valid_next;
    end
  end

  // Datapath and result payload registers.
  always_ff @(posedge clk) begin
    work     <= work_next;
    radix_r  <= radix_r_next;
    rem      <= rem_next;
    qnz      <= qnz_next;
    out_char <= out_char_next;
    out_last <= out_last_next;
    out_bad  <= out_bad_next;
  end

  // Digit stack: a push shifts toward the bottom, a pop shifts toward the top.
  always_ff @(posedge clk) begin
    if (push) begin
      stack[0] <= div_rem[DIGIT_W-1:0];
      for (int i = 1; i < VALUE_BITS; i++) begin
        stack[i] <= stack[i-1];
      end
    end else if (pop) begin
      for (int i = 0; i < VALUE_BITS - 1; i++) begin
        stack[i] <= stack[i+1];
      end
    end
  end

  assign result.valid      = out_valid;
  assign result.digit_char = out_char;
  assign result.last       = out_last;
  assign result.bad_radix  = out_bad;

  // A bad radix result is always the single, final result with a zero character.
  a_bad_is_last: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.bad_radix |-> result.last && (result.digit_char == ERROR_CHAR))
    else $error("bad radix result not a lone zero character");

  // The digit count never exceeds the stack depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(VALUE_BITS))
    else $error("digit count beyond stack depth");

  // Emitting digits always has at least one digit on the stack.
  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) && !bad |-> (count != '0))
    else $error("digit emission with empty stack");

  // The divide phase ends with at least one digit pushed.
  a_divide_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIVIDE) && (state_next == ST_EMIT) |=> (count != '0))
    else $error("divide finished without a digit");

endmodule

`default_nettype wire
